[design/trd_pkg.sv]
// shared types and constants for the tls record deframer
`timescale 1ns / 1ps

package trd_pkg;

    localparam logic [7:0] TYPE_ALERT = 8'h15;
    localparam logic [7:0] TYPE_HS    = 8'h16;
    localparam logic [7:0] TYPE_APP   = 8'h17;

    localparam logic [16:0] HDR_BYTES   = 17'd5;
    localparam logic [16:0] MAX_LEN_RST = 17'd12288;

    localparam logic [2:0] HDR_TYPE    = 3'd0;
    localparam logic [2:0] HDR_VER_HI  = 3'd1;
    localparam logic [2:0] HDR_VER_LO  = 3'd2;
    localparam logic [2:0] HDR_LEN_HI  = 3'd3;
    localparam logic [2:0] HDR_LEN_LO  = 3'd4;
    localparam logic [2:0] HDR_PAYLOAD = 3'd5;

    typedef struct packed {
        logic [2:0]  hdr_idx;
        logic [7:0]  cur_type;
        logic [15:0] len;
        logic [15:0] pos;
        logic        fail;
        logic        seen;
        logic [7:0]  first_type;
        logic [7:0]  latest_type;
        logic [7:0]  alert_level;
        logic [7:0]  alert_desc;
        logic [7:0]  alert_hold;
    } t_state;

    typedef struct packed {
        logic       payload_valid;
        logic [7:0] payload_byte;
        logic [7:0] content_type;
        logic       last_in_record;
        logic       empty_record;
        logic       stream_failed;
        logic       byte_dropped;
        logic       any_record_seen;
        logic [7:0] first_type;
        logic [7:0] latest_type;
        logic [7:0] alert_level;
        logic [7:0] alert_desc;
    } t_result;

    function automatic logic is_forwarded(input logic [7:0] t);
        return (t == TYPE_HS) || (t == TYPE_APP);
    endfunction

endpackage

[design/trd_step.sv]
// per-byte next-state and result logic of the record deframer
`timescale 1ns / 1ps

module trd_step (
    input  trd_pkg::t_state  i_state,
    input  logic [7:0]       i_byte,
    input  logic [16:0]      i_max_len,
    output trd_pkg::t_state  o_state,
    output trd_pkg::t_result o_result
);

    trd_pkg::t_state  n;
    trd_pkg::t_result res;
    logic [15:0]      len_full;
    logic             final_byte;
    logic             rec_end;

    always_comb begin
        n          = i_state;
        res        = '0;
        rec_end    = 1'b0;
        len_full   = {i_state.len[15:8], i_byte};
        final_byte = ({1'b0, i_state.pos} + 17'd1) >= {1'b0, i_state.len};

        if (i_state.fail) begin
            res.byte_dropped = 1'b1;
        end else begin
            case (i_state.hdr_idx)
                trd_pkg::HDR_TYPE: begin
                    n.cur_type = i_byte;
                    n.hdr_idx  = trd_pkg::HDR_VER_HI;
                end
                trd_pkg::HDR_VER_HI: begin
                    n.hdr_idx = trd_pkg::HDR_VER_LO;
                end
                trd_pkg::HDR_VER_LO: begin
                    n.hdr_idx = trd_pkg::HDR_LEN_HI;
                end
                trd_pkg::HDR_LEN_HI: begin
                    n.len     = {i_byte, 8'h00};
                    n.hdr_idx = trd_pkg::HDR_LEN_LO;
                end
                trd_pkg::HDR_LEN_LO: begin
                    n.len = len_full;
                    if (({1'b0, len_full} + trd_pkg::HDR_BYTES) > i_max_len) begin
                        n.fail    = 1'b1;
                        n.hdr_idx = trd_pkg::HDR_TYPE;
                    end else if (len_full == 16'd0) begin
                        rec_end = 1'b1;
                        if (trd_pkg::is_forwarded(i_state.cur_type)) begin
                            res.content_type   = i_state.cur_type;
                            res.last_in_record = 1'b1;
                            res.empty_record   = 1'b1;
                        end
                    end else begin
                        n.hdr_idx = trd_pkg::HDR_PAYLOAD;
                        n.pos     = 16'd0;
                    end
                end
                default: begin
                    if (trd_pkg::is_forwarded(i_state.cur_type)) begin
                        res.payload_valid  = 1'b1;
                        res.payload_byte   = i_byte;
                        res.content_type   = i_state.cur_type;
                        res.last_in_record = final_byte;
                    end else if (i_state.cur_type == trd_pkg::TYPE_ALERT) begin
                        if (i_state.pos == 16'd0) begin
                            n.alert_hold = i_byte;
                        end else if (i_state.pos == 16'd1) begin
                            n.alert_level = i_state.alert_hold;
                            n.alert_desc  = i_byte;
                        end
                    end
                    if (final_byte) begin
                        rec_end = 1'b1;
                    end else begin
                        n.pos = i_state.pos + 16'd1;
                    end
                end
            endcase
        end

        // record bookkeeping
        if (rec_end) begin
            if (!i_state.seen) begin
                n.seen       = 1'b1;
                n.first_type = i_state.cur_type;
            end
            n.latest_type = i_state.cur_type;
            if (i_state.cur_type == trd_pkg::TYPE_ALERT) begin
                n.fail = 1'b1;
            end
            n.hdr_idx = trd_pkg::HDR_TYPE;
            n.pos     = 16'd0;
        end

        res.stream_failed   = n.fail;
        res.any_record_seen = n.seen;
        res.first_type      = n.first_type;
        res.latest_type     = n.latest_type;
        res.alert_level     = n.alert_level;
        res.alert_desc      = n.alert_desc;
    end

    assign o_state  = n;
    assign o_result = res;

endmodule

[design/tls_record_deframer.sv]
// top level of the tls record deframer
`timescale 1ns / 1ps
// Splits a received byte stream into TLS records, one byte per request.
// Input channel i_valid / o_ready carries i_rx_byte. Output channel
// o_valid / i_ready carries one result per accepted byte: forwarded
// payload of handshake and application records with type and last mark,
// an empty marker for zero-length forwarded records, and the status
// fields (failed, dropped, record types seen, last alert bytes).
// The result of an accepted byte is registered and presented in the cycle
// after it is taken. Throughput is one byte per cycle while i_ready keeps the
// output register draining; the header and counter update sits between the
// state registers and the output register and is combinational.
// A stalled receiver holds the output register; a new byte is still
// taken in the cycle the waiting result leaves (o_ready follows i_ready
// while the output register is full).
// The max record length register is written on i_cfg_valid / o_cfg_ready,
// which is always ready; write it only while the block is idle.
// Synchronous active-low reset clears all state, sets the max record
// length to 12288 and empties the output register.

module tls_record_deframer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [16:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_payload_valid,
    output logic [7:0]  o_payload_byte,
    output logic [7:0]  o_content_type,
    output logic        o_last_in_record,
    output logic        o_empty_record,
    output logic        o_stream_failed,
    output logic        o_byte_dropped,
    output logic        o_any_record_seen,
    output logic [7:0]  o_first_type,
    output logic [7:0]  o_latest_type,
    output logic [7:0]  o_alert_level_out,
    output logic [7:0]  o_alert_desc_out
);

    trd_pkg::t_state  r_state;
    trd_pkg::t_state  n_state;
    trd_pkg::t_result r_result;
    trd_pkg::t_result n_result;
    logic [16:0]      r_max_len;
    logic             r_out_valid;
    logic             in_take;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = !r_out_valid || i_ready;
    assign in_take     = i_valid && o_ready;

    trd_step u_step (
        .i_state  (r_state),
        .i_byte   (i_rx_byte),
        .i_max_len(r_max_len),
        .o_state  (n_state),
        .o_result (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= trd_pkg::MAX_LEN_RST;
        end else if (i_cfg_valid) begin
            r_max_len <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (in_take) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_take) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_result <= n_result;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_payload_valid   = r_result.payload_valid;
    assign o_payload_byte    = r_result.payload_byte;
    assign o_content_type    = r_result.content_type;
    assign o_last_in_record  = r_result.last_in_record;
    assign o_empty_record    = r_result.empty_record;
    assign o_stream_failed   = r_result.stream_failed;
    assign o_byte_dropped    = r_result.byte_dropped;
    assign o_any_record_seen = r_result.any_record_seen;
    assign o_first_type      = r_result.first_type;
    assign o_latest_type     = r_result.latest_type;
    assign o_alert_level_out = r_result.alert_level;
    assign o_alert_desc_out  = r_result.alert_desc;

`ifndef SYNTHESIS
    // failure is sticky until reset
    a_fail_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.fail |=> r_state.fail)
        else $error("failed flag cleared without reset");

    // header index never leaves the header and payload range
    a_hdr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.hdr_idx <= trd_pkg::HDR_PAYLOAD)
        else $error("header index out of range");

    // empty marker is a last mark without a payload byte
    a_empty_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_empty_record) |-> (o_last_in_record && !o_payload_valid))
        else $error("malformed empty marker");

    // a dropped byte only follows failure and forwards nothing
    a_dropped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_byte_dropped) |-> (o_stream_failed && !o_payload_valid))
        else $error("dropped byte without failure");
`endif

endmodule
